/* design/lru_last_value_predictor_assert.svh */
// ----------------------------------------------------------------------------
// LRU last-value predictor assertion macros
// Shared property shapes for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef LRU_LAST_VALUE_PREDICTOR_ASSERT_SVH
`define LRU_LAST_VALUE_PREDICTOR_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define LVP_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LVP_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/lvp_pkg.sv */
// ----------------------------------------------------------------------------
// LRU last-value predictor package
// Shared constants, item and result types.
// ----------------------------------------------------------------------------
package lvp_pkg;

    localparam int LVP_ENTRIES = 64;
    localparam int LVP_DATA_W  = 64;

    localparam logic [LVP_DATA_W-1:0] LVP_SENTINEL = 64'h0000_0000_dead_beef;

    typedef enum logic
    {
        LVP_PREDICT = 1'b0,
        LVP_UPDATE  = 1'b1
    } lvp_action_t;

    typedef struct packed
    {
        lvp_action_t           action;
        logic                  eligible;
        logic [LVP_DATA_W-1:0] load_pc;
        logic [LVP_DATA_W-1:0] load_address;
        logic [LVP_DATA_W-1:0] load_value;
    } lvp_item_t;

    typedef struct packed
    {
        logic [LVP_DATA_W-1:0] pred_value;
        logic                  speculate;
    } lvp_result_t;

endpackage

/* design/lvp_table.sv */
// ----------------------------------------------------------------------------
// LRU last-value predictor table
// Fully associative entry array: tag match, prediction and LRU update.
// ----------------------------------------------------------------------------
module lvp_table #(
    parameter int ENTRIES = lvp_pkg::LVP_ENTRIES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  lvp_pkg::lvp_item_t  item,
    output lvp_pkg::lvp_result_t result
);
    import lvp_pkg::*;

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    // entries fill in index order and are never freed, so valid is a prefix
    logic [CW-1:0]         fill_reg, fill_next;
    logic [RW-1:0]         rank_reg [ENTRIES];
    logic [RW-1:0]         rank_next [ENTRIES];
    logic [LVP_DATA_W-1:0] tag_reg   [ENTRIES];
    logic [LVP_DATA_W-1:0] newer_reg [ENTRIES];
    logic                  same_reg  [ENTRIES];

    logic [ENTRIES-1:0]    valid;
    logic [ENTRIES-1:0]    hit_vec;
    logic [ENTRIES-1:0]    write_vec;
    logic                  hit;
    logic                  full;
    logic                  upd_ok;
    logic [RW-1:0]         hit_rank;
    logic [LVP_DATA_W-1:0] hit_newer;
    logic                  hit_same;
    logic [CW-1:0]         old_rank;
    logic [LVP_DATA_W-1:0] new_older;
    logic                  new_same;

    always_comb
    begin
        hit_rank  = '0;
        hit_newer = '0;
        hit_same  = 1'b0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            valid[i]   = CW'(i) < fill_reg;
            hit_vec[i] = valid[i] && (tag_reg[i] == item.load_pc);
            // tags are unique, so at most one entry matches
            hit_rank  = hit_rank  | (hit_vec[i] ? rank_reg[i]  : '0);
            hit_newer = hit_newer | (hit_vec[i] ? newer_reg[i] : '0);
            hit_same  = hit_same  | (hit_vec[i] && same_reg[i]);
        end
        hit  = |hit_vec;
        full = fill_reg == CW'(ENTRIES);

        upd_ok = fire && (item.action == LVP_UPDATE)
                 && (item.load_address != LVP_SENTINEL)
                 && (item.load_value != LVP_SENTINEL);

        // ranks of valid entries form a permutation, so the LRU entry
        // is the one ranked last
        if (hit)
            old_rank = CW'(hit_rank);
        else if (full)
            old_rank = CW'(ENTRIES - 1);
        else
            old_rank = CW'(ENTRIES);

        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit)
                write_vec[i] = hit_vec[i];
            else if (full)
                write_vec[i] = rank_reg[i] == RW'(ENTRIES - 1);
            else
                write_vec[i] = CW'(i) == fill_reg;
        end

        new_older = hit ? hit_newer : LVP_SENTINEL;
        new_same  = new_older == item.load_value;

        for (int i = 0; i < ENTRIES; i++)
        begin
            rank_next[i] = rank_reg[i];
            if (upd_ok)
            begin
                if (write_vec[i])
                    rank_next[i] = '0;
                else if (valid[i] && (CW'(rank_reg[i]) < old_rank))
                    rank_next[i] = rank_reg[i] + RW'(1);
            end
        end

        fill_next = fill_reg;
        if (upd_ok && !hit && !full)
            fill_next = fill_reg + CW'(1);

        result.speculate  = item.eligible && hit && hit_same;
        result.pred_value = result.speculate ? hit_newer : LVP_SENTINEL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            for (int i = 0; i < ENTRIES; i++)
                rank_reg[i] <= rank_next[i];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (upd_ok && write_vec[i])
            begin
                tag_reg[i]   <= item.load_pc;
                newer_reg[i] <= item.load_value;
                same_reg[i]  <= new_same;
            end
        end
    end

endmodule

/* design/lru_last_value_predictor.sv */
// ----------------------------------------------------------------------------
// LRU last-value predictor
// Load value history table keyed by PC, with LRU replacement.
// ----------------------------------------------------------------------------
// Takes one item per cycle. An item is registered on acceptance and looked up
// in the entry array in the following cycle; a prediction request's result is
// loaded into the output register when the item leaves the input register and
// is offered on m_axis from then on, and an update gives no result. The only
// stall is a prediction request meeting a full output register that is not
// being taken. Updates take effect before the next item is looked up, so
// back-to-back items always see current state. No clearing pass after reset:
// valid entries are tracked by a fill count.
module lru_last_value_predictor #(
    parameter int ENTRIES = lvp_pkg::LVP_ENTRIES
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // load_pc, load_address, load_value
    input  logic [1:0]   s_axis_tuser,  // action, eligible
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // pred_value
    output logic [0:0]   m_axis_tuser   // speculate
);
    import lvp_pkg::*;

    logic        in_valid_reg, in_valid_next;
    lvp_item_t   item_reg;
    logic        out_valid_reg, out_valid_next;
    lvp_result_t out_reg;
    lvp_result_t lookup;
    logic        advance;
    logic        s_fire;

    assign advance = in_valid_reg
                     && ((item_reg.action == LVP_UPDATE) || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = s_axis_tready ? s_axis_tvalid : in_valid_reg;
        if (advance && (item_reg.action == LVP_PREDICT))
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            item_reg.action       <= lvp_action_t'(s_axis_tuser[0]);
            item_reg.eligible     <= s_axis_tuser[1];
            item_reg.load_pc      <= s_axis_tdata[63:0];
            item_reg.load_address <= s_axis_tdata[127:64];
            item_reg.load_value   <= s_axis_tdata[191:128];
        end
        if (advance && (item_reg.action == LVP_PREDICT))
            out_reg <= lookup;
    end

    lvp_table #(
        .ENTRIES (ENTRIES)
    ) u_table (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item_reg),
        .result (lookup)
    );

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_reg.pred_value;
    assign m_axis_tuser[0] = out_reg.speculate;

endmodule

/* design/lvp_checker.sv */
// ----------------------------------------------------------------------------
// LRU last-value predictor checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "lru_last_value_predictor_assert.svh"

module lvp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [63:0]  m_axis_tdata,
    input logic [0:0]   m_axis_tuser
);
    import lvp_pkg::*;

    logic        out_stalled;
    logic        out_plain;
    logic [65:0] out_word;

    assign out_stalled = m_axis_tvalid && !m_axis_tready;
    assign out_plain   = m_axis_tvalid && !m_axis_tuser[0];
    assign out_word    = {m_axis_tvalid, m_axis_tuser, m_axis_tdata};

    // a stalled result item holds
    `LVP_ASSERT_NEXT(a_out_hold, out_stalled, $stable(out_word), "result changed while stalled")

    // no speculation means the sentinel
    `LVP_ASSERT_NOW(a_sentinel, out_plain, m_axis_tdata == LVP_SENTINEL, "sentinel expected")

    // input only stalls behind a blocked result
    `LVP_ASSERT_NOW(a_stall_cause, !s_axis_tready, out_stalled, "input stalled without cause")

endmodule

bind lru_last_value_predictor lvp_checker u_lvp_checker (.*);

/* sim/lru_last_value_predictor_checker.sv */
// ----------------------------------------------------------------------------
// LRU last-value predictor checker
// Watches both stream ports, keeps its own copy of the history table and
// compares every prediction leaving the block against the predicted answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_last_value_predictor_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,  // load_pc, load_address, load_value
    input  logic [1:0]   s_axis_tuser,  // action, eligible
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [63:0]  m_axis_tdata,  // pred_value
    input  logic [0:0]   m_axis_tuser,  // speculate
    output int           fail_count,
    output int           outstanding
);
    import lvp_pkg::*;

    localparam int SLOTS = LVP_ENTRIES;

    bit                    slot_valid [SLOTS];
    logic [LVP_DATA_W-1:0] slot_tag   [SLOTS];
    logic [LVP_DATA_W-1:0] slot_older [SLOTS];
    logic [LVP_DATA_W-1:0] slot_newer [SLOTS];
    int unsigned           slot_rank  [SLOTS];

    lvp_result_t pending_predictions[$];
    int          mismatches = 0;

    lvp_item_t   seen_item;
    lvp_result_t seen_result;
    lvp_result_t wanted;

    assign fail_count = mismatches;

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic int find_slot(input logic [LVP_DATA_W-1:0] pc);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (slot_valid[i] && slot_tag[i] == pc)
                return i;
        end
        return -1;
    endfunction

    // entry k becomes most recent; valid entries newer than it age by one
    function automatic void promote(input int k, input int unsigned old_rank);
        for (int i = 0; i < SLOTS; i++)
        begin
            if (i != k && slot_valid[i] && slot_rank[i] < old_rank)
                slot_rank[i]++;
        end
        slot_rank[k] = 0;
    endfunction

    function automatic lvp_result_t predict_load(input lvp_item_t it);
        lvp_result_t r;
        int          k;
        r.pred_value = LVP_SENTINEL;
        r.speculate  = 1'b0;
        if (it.eligible)
        begin
            k = find_slot(it.load_pc);
            if (k >= 0 && slot_older[k] == slot_newer[k])
            begin
                r.pred_value = slot_newer[k];
                r.speculate  = 1'b1;
            end
        end
        return r;
    endfunction

    function automatic void retire_load(input lvp_item_t it);
        int k;
        if (it.load_address == LVP_SENTINEL || it.load_value == LVP_SENTINEL)
            return;
        k = find_slot(it.load_pc);
        if (k >= 0)
        begin
            slot_older[k] = slot_newer[k];
            slot_newer[k] = it.load_value;
            promote(k, slot_rank[k]);
            return;
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_valid[i] && k < 0)
                k = i;
        end
        if (k < 0)
        begin
            // table full: evict the oldest
            k = 0;
            for (int i = 1; i < SLOTS; i++)
            begin
                if (slot_rank[i] > slot_rank[k])
                    k = i;
            end
            promote(k, slot_rank[k]);
        end
        else
        begin
            promote(k, SLOTS);
        end
        slot_valid[k] = 1'b1;
        slot_tag[k]   = it.load_pc;
        slot_older[k] = LVP_SENTINEL;
        slot_newer[k] = it.load_value;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_valid[i] = 1'b0;
                slot_tag[i]   = '0;
                slot_older[i] = '0;
                slot_newer[i] = '0;
                slot_rank[i]  = 0;
            end
            pending_predictions.delete();
            outstanding <= 0;
        end
        else
        begin
            // results leaving now belong to items taken on earlier edges
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_result.pred_value = m_axis_tdata;
                seen_result.speculate  = m_axis_tuser[0];
                if (pending_predictions.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected item: value %h speculate %b",
                                              seen_result.pred_value,
                                              seen_result.speculate));
                end
                else
                begin
                    wanted = pending_predictions.pop_front();
                    if (seen_result.pred_value !== wanted.pred_value)
                        report_mismatch($sformatf("pred_value %h, want %h",
                                                  seen_result.pred_value,
                                                  wanted.pred_value));
                    if (seen_result.speculate !== wanted.speculate)
                        report_mismatch($sformatf("speculate %b, want %b",
                                                  seen_result.speculate,
                                                  wanted.speculate));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                seen_item.load_pc      = s_axis_tdata[63:0];
                seen_item.load_address = s_axis_tdata[127:64];
                seen_item.load_value   = s_axis_tdata[191:128];
                seen_item.action       = lvp_action_t'(s_axis_tuser[0]);
                seen_item.eligible     = s_axis_tuser[1];
                if (seen_item.action == LVP_PREDICT)
                    pending_predictions.push_back(predict_load(seen_item));
                else
                    retire_load(seen_item);
            end
            outstanding <= pending_predictions.size();
        end
    end

endmodule

/* sim/lru_last_value_predictor_tb.sv */
// ----------------------------------------------------------------------------
// LRU last-value predictor testbench
// Directed corner items, then random prediction and update traffic over a
// PC pool larger than the table, under varying back-pressure on both ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_last_value_predictor_tb;

    import lvp_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 10;
    localparam int PC_POOL         = 128;
    localparam int HOT_PCS         = 16;
    localparam int PHASE_ITEMS     = 130;
    localparam int BURST_ITEMS     = 40;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata  = '0;   // load_pc, load_address, load_value
    logic [1:0]   s_axis_tuser  = '0;   // action, eligible
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [63:0]  m_axis_tdata;         // pred_value
    logic [0:0]   m_axis_tuser;         // speculate

    int fail_count;
    int outstanding;

    int send_idle_pct = 17;
    int recv_idle_pct = 53;
    bit stall_go      = 1'b0;
    bit stall_used    = 1'b0;
    int stall_left    = 0;
    int quiet_cycles  = 0;

    logic [LVP_DATA_W-1:0] pc_pool    [PC_POOL];
    logic [LVP_DATA_W-1:0] value_pool [2];

    always #2 clk = ~clk;

    lru_last_value_predictor dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lru_last_value_predictor_checker lvp_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .outstanding   (outstanding)
    );

    // result side: random idling, plus one long hold-off on request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
            stall_used    <= 1'b0;
        end
        else if (stall_go && !stall_used)
        begin
            stall_used    <= 1'b1;
            stall_left    <= HOLD_OFF_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("lru_last_value_predictor_tb NOT OK");
                    $finish;
                end
            end
        end
    end

    function automatic lvp_item_t load_item(input lvp_action_t act,
                                            input logic [63:0] pc,
                                            input logic        cand,
                                            input logic [63:0] addr,
                                            input logic [63:0] val);
        lvp_item_t it;
        it.action       = act;
        it.load_pc      = pc;
        it.eligible     = cand;
        it.load_address = addr;
        it.load_value   = val;
        return it;
    endfunction

    function automatic lvp_item_t random_load_item();
        lvp_item_t it;
        int        pick;
        if ($urandom_range(0, 99) < 50)
            it.action = LVP_UPDATE;
        else
            it.action = LVP_PREDICT;
        if ($urandom_range(0, 99) < 60)
            it.load_pc = pc_pool[$urandom_range(0, HOT_PCS - 1)];
        else
            it.load_pc = pc_pool[$urandom_range(0, PC_POOL - 1)];
        it.eligible     = ($urandom_range(0, 99) < 85);
        it.load_address = {$urandom, $urandom};
        it.load_value   = {$urandom, $urandom};
        if (it.action == LVP_UPDATE)
        begin
            // few distinct values so that repeats, and thus speculation, happen
            pick = $urandom_range(0, 99);
            if (pick < 75)
                it.load_value = value_pool[$urandom_range(0, 1)];
            else if (pick < 82)
                it.load_value = LVP_SENTINEL;
            if ($urandom_range(0, 99) < 6)
                it.load_address = LVP_SENTINEL;
        end
        return it;
    endfunction

    task automatic offer_item(input lvp_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.load_value, it.load_address, it.load_pc};
        s_axis_tuser  <= {it.eligible, it.action};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_for_results();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    initial
    begin
        lvp_item_t directed[$];
        lvp_item_t it;
        logic [63:0] ones;

        ones = '1;
        for (int i = 0; i < PC_POOL; i++)
            pc_pool[i] = {$urandom, $urandom};
        value_pool[0] = {$urandom, $urandom};
        value_pool[1] = {$urandom, $urandom};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table, ignored updates, fresh entry, then a matching pair
        directed.push_back(load_item(LVP_PREDICT, '0, 1'b1, ones, ones));
        directed.push_back(load_item(LVP_UPDATE, '0, 1'b0, LVP_SENTINEL, 64'd5));
        directed.push_back(load_item(LVP_UPDATE, '0, 1'b1, 64'd1, LVP_SENTINEL));
        directed.push_back(load_item(LVP_PREDICT, '0, 1'b1, '0, '0));
        directed.push_back(load_item(LVP_UPDATE, '0, 1'b0, '0, '0));
        directed.push_back(load_item(LVP_PREDICT, '0, 1'b1, '0, '0));
        directed.push_back(load_item(LVP_UPDATE, '0, 1'b1, ones, '0));
        directed.push_back(load_item(LVP_PREDICT, '0, 1'b1, ones, LVP_SENTINEL));
        directed.push_back(load_item(LVP_PREDICT, '0, 1'b0, '0, '0));
        directed.push_back(load_item(LVP_UPDATE, ones, 1'b0, ones, ones));
        directed.push_back(load_item(LVP_UPDATE, ones, 1'b1, ones, ones));
        directed.push_back(load_item(LVP_PREDICT, ones, 1'b1, ones, ones));
        directed.push_back(load_item(LVP_PREDICT, ones, 1'b0, ones, ones));
        // near-sentinel value is a real value
        directed.push_back(load_item(LVP_UPDATE, ones, 1'b0, '0, 64'hffff_ffff_dead_beef));
        directed.push_back(load_item(LVP_PREDICT, ones, 1'b1, '0, '0));
        directed.push_back(load_item(LVP_UPDATE, ones, 1'b0, '0, 64'hffff_ffff_dead_beef));
        directed.push_back(load_item(LVP_PREDICT, ones, 1'b1, '0, '0));
        directed.push_back(load_item(LVP_UPDATE, '0, 1'b0, 64'd2, 64'd7));
        directed.push_back(load_item(LVP_PREDICT, '0, 1'b1, '0, '0));
        directed.push_back(load_item(LVP_PREDICT, 64'h1234_5678_9abc_def0, 1'b1, '0, '0));
        foreach (directed[i])
            offer_item(directed[i]);
        wait_for_results();

        repeat (PHASE_ITEMS) offer_item(random_load_item());

        // long result hold-off with predictions queued behind it
        stall_go <= 1'b1;
        repeat (BURST_ITEMS)
        begin
            it = random_load_item();
            it.action = LVP_PREDICT;
            offer_item(it);
        end
        wait_for_results();

        send_idle_pct = 53;
        recv_idle_pct = 17;
        repeat (PHASE_ITEMS) offer_item(random_load_item());
        wait_for_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (PHASE_ITEMS) offer_item(random_load_item());
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("lru_last_value_predictor_tb OK");
        else
            $display("lru_last_value_predictor_tb NOT OK");
        $finish;
    end

endmodule
